### src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is high.
`define FPST_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Concurrent check that also holds during reset.
`define FPST_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

### src/fpst_pkg.sv
// Types and constants of the binary indexed prefix-sum table.
package fpst_pkg;

   localparam int SUM_W        = 48;
   localparam int POS_W        = 11;
   localparam int IDX_W        = 12;
   localparam int KIND_W       = 2;
   localparam int SIZE_DEFAULT = 1024;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 2'd0,
      KIND_QUERY  = 2'd1,
      KIND_SEARCH = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_FINISH
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [SUM_W-1:0] a;
      logic [SUM_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             b_lt_a;
   } alu_rsp_type;

endpackage

### src/fpst_mem.sv
// Node store: one write port, one registered read port.
module fpst_mem #(
   parameter int DEPTH = fpst_pkg::SIZE_DEFAULT,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [AW-1:0]              waddr,
   input  logic [fpst_pkg::SUM_W-1:0] wdata,
   input  logic                       re,
   input  logic [AW-1:0]              raddr,
   output logic [fpst_pkg::SUM_W-1:0] rdata
);

   logic [fpst_pkg::SUM_W-1:0] mem [DEPTH];
   logic [fpst_pkg::SUM_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/fpst_alu.sv
// Shared 48-bit add/subtract unit with signed compare.
module fpst_alu (
   input  fpst_pkg::alu_req_type req,
   output fpst_pkg::alu_rsp_type rsp
);

   logic                       sub;
   logic [fpst_pkg::SUM_W-1:0] b_eff;

   assign sub        = (req.op == fpst_pkg::ALU_SUB);
   assign b_eff      = sub ? ~req.b : req.b;
   assign rsp.sum    = req.a + b_eff + fpst_pkg::SUM_W'(sub);
   assign rsp.b_lt_a = $signed(req.b) < $signed(req.a);

endmodule

### src/fpst_seq.sv
// Sequencer: clearing pass, tree walks for add, query and search, result register.
module fpst_seq #(
   parameter int SIZE = fpst_pkg::SIZE_DEFAULT,
   localparam int AW = $clog2(SIZE)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fpst_pkg::KIND_W-1:0]       req_kind,
   input  logic [fpst_pkg::POS_W-1:0]        req_position,
   input  logic signed [fpst_pkg::SUM_W-1:0] req_amount,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [fpst_pkg::SUM_W-1:0] rsp_prefix_sum,
   output logic signed [fpst_pkg::IDX_W-1:0] rsp_found_index,
   output logic                              mem_we,
   output logic [AW-1:0]                     mem_waddr,
   output logic [fpst_pkg::SUM_W-1:0]        mem_wdata,
   output logic                              mem_re,
   output logic [AW-1:0]                     mem_raddr,
   input  logic [fpst_pkg::SUM_W-1:0]        mem_rdata,
   output fpst_pkg::alu_req_type             alu_req,
   input  fpst_pkg::alu_rsp_type             alu_rsp
);

   localparam int PW = AW + 1;
   localparam int IW = $clog2(SIZE + 1);
   localparam int CW = (PW > fpst_pkg::POS_W) ? PW : fpst_pkg::POS_W;
   localparam logic [PW-1:0] SIZE_P   = PW'(SIZE);
   localparam logic [PW:0]   SIZE_E   = (PW + 1)'(SIZE);
   localparam logic [CW-1:0] SIZE_C   = CW'(SIZE);
   localparam logic [IW-1:0] STEP_TOP = {1'b1, {(IW - 1){1'b0}}};
   localparam logic [AW-1:0] LAST_A   = AW'(SIZE - 1);

   fpst_pkg::state_type state_ff, state_in;
   fpst_pkg::kind_type  kind_ff, kind_in;
   logic [PW-1:0]       ptr_ff, ptr_in;
   logic [IW-1:0]       step_ff, step_in;
   logic [fpst_pkg::SUM_W-1:0] acc_ff, acc_in;
   logic                neg_ff, neg_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [fpst_pkg::SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic [fpst_pkg::IDX_W-1:0] rsp_idx_ff, rsp_idx_in;

   logic                accept;
   logic                out_free;
   logic [CW-1:0]       pos_c;
   logic [PW:0]         cand;
   logic                cand_fit;
   logic [PW-1:0]       add_next;
   logic [PW-1:0]       qry_next;
   logic [IW-1:0]       step_half;
   logic [AW-1:0]       rd_addr;
   logic                is_search;

   assign req_ready = (state_ff == fpst_pkg::ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pos_c     = CW'(req_position);
   assign cand      = {1'b0, ptr_ff} + (PW + 1)'(step_ff);
   assign cand_fit  = (cand <= SIZE_E);
   assign add_next  = ptr_ff | (ptr_ff + PW'(1));
   assign qry_next  = ptr_ff & (ptr_ff - PW'(1));
   assign step_half = step_ff >> 1;
   assign is_search = (kind_ff == fpst_pkg::KIND_SEARCH);

   always_comb begin
      case (kind_ff)
         fpst_pkg::KIND_QUERY:  rd_addr = AW'(ptr_ff - PW'(1));
         fpst_pkg::KIND_SEARCH: rd_addr = AW'(cand - (PW + 1)'(1));
         default:               rd_addr = ptr_ff[AW-1:0];
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fpst_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_A) begin
               state_in = fpst_pkg::ST_IDLE;
            end
         end
         fpst_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = fpst_pkg::ST_FINISH;
               case (req_kind)
                  fpst_pkg::KIND_ADD: begin
                     if (pos_c < SIZE_C) state_in = fpst_pkg::ST_READ;
                  end
                  fpst_pkg::KIND_QUERY: begin
                     if (pos_c != '0) state_in = fpst_pkg::ST_READ;
                  end
                  fpst_pkg::KIND_SEARCH: begin
                     if (!req_amount[fpst_pkg::SUM_W-1] && req_amount != '0) begin
                        state_in = fpst_pkg::ST_READ;
                     end
                  end
                  default: state_in = fpst_pkg::ST_FINISH;
               endcase
            end
         end
         fpst_pkg::ST_READ: begin
            if (is_search && !cand_fit) begin
               if (step_half == '0) state_in = fpst_pkg::ST_FINISH;
            end else begin
               state_in = fpst_pkg::ST_EXEC;
            end
         end
         fpst_pkg::ST_EXEC: begin
            case (kind_ff)
               fpst_pkg::KIND_ADD:
                  state_in = (add_next < SIZE_P) ? fpst_pkg::ST_READ : fpst_pkg::ST_FINISH;
               fpst_pkg::KIND_QUERY:
                  state_in = (qry_next == '0) ? fpst_pkg::ST_FINISH : fpst_pkg::ST_READ;
               fpst_pkg::KIND_SEARCH:
                  state_in = (step_half == '0) ? fpst_pkg::ST_FINISH : fpst_pkg::ST_READ;
               default: state_in = fpst_pkg::ST_FINISH;
            endcase
         end
         fpst_pkg::ST_FINISH: begin
            if (out_free) state_in = fpst_pkg::ST_IDLE;
         end
         default: state_in = fpst_pkg::ST_CLEAR;
      endcase
   end

   // datapath and outputs
   always_comb begin
      kind_in      = kind_ff;
      ptr_in       = ptr_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      addr_in      = addr_ff;
      clr_in       = clr_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = alu_rsp.sum;
      mem_re       = 1'b0;
      mem_raddr    = rd_addr;
      alu_req.op   = fpst_pkg::ALU_ADD;
      alu_req.a    = acc_ff;
      alu_req.b    = mem_rdata;
      unique case (state_ff)
         fpst_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
         end
         fpst_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in = fpst_pkg::kind_type'(req_kind);
               step_in = STEP_TOP;
               neg_in  = req_amount[fpst_pkg::SUM_W-1] || (req_amount == '0);
               acc_in  = req_amount;
               case (req_kind)
                  fpst_pkg::KIND_QUERY: begin
                     acc_in = '0;
                     ptr_in = (pos_c > SIZE_C) ? SIZE_P : PW'(req_position);
                  end
                  fpst_pkg::KIND_SEARCH: ptr_in = '0;
                  default:               ptr_in = PW'(req_position);
               endcase
            end
         end
         fpst_pkg::ST_READ: begin
            if (is_search && !cand_fit) begin
               step_in = step_half;
            end else begin
               mem_re  = 1'b1;
               addr_in = rd_addr;
            end
         end
         fpst_pkg::ST_EXEC: begin
            case (kind_ff)
               fpst_pkg::KIND_ADD: begin
                  alu_req.a = mem_rdata;
                  alu_req.b = acc_ff;
                  mem_we    = 1'b1;
                  ptr_in    = add_next;
               end
               fpst_pkg::KIND_QUERY: begin
                  acc_in = alu_rsp.sum;
                  ptr_in = qry_next;
               end
               fpst_pkg::KIND_SEARCH: begin
                  alu_req.op = fpst_pkg::ALU_SUB;
                  step_in    = step_half;
                  if (alu_rsp.b_lt_a) begin
                     ptr_in = cand[PW-1:0];
                     acc_in = alu_rsp.sum;
                  end
               end
               default: ptr_in = ptr_ff;
            endcase
         end
         fpst_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = (kind_ff == fpst_pkg::KIND_QUERY) ? acc_ff : '0;
               if (is_search) begin
                  rsp_idx_in = neg_ff ? '1 : fpst_pkg::IDX_W'(ptr_ff);
               end else begin
                  rsp_idx_in = '0;
               end
            end
         end
         default: clr_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpst_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      ptr_ff     <= ptr_in;
      step_ff    <= step_in;
      acc_ff     <= acc_in;
      neg_ff     <= neg_in;
      addr_ff    <= addr_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_idx_ff <= rsp_idx_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prefix_sum  = rsp_sum_ff;
   assign rsp_found_index = rsp_idx_ff;

endmodule

### src/fenwick_prefix_sum_table.sv
// From accept to result the sequencer visits each tree node in a read state and then an
// execute state, as the read port of the node store is registered. One transaction runs at
// a time; the next is accepted in the cycle after the result is loaded. A finished result
// waits in the output register while the next transaction runs. Reset (synchronous, active
// high) starts a clearing pass over the node store, with req_ready low until it completes.
module fenwick_prefix_sum_table #(
   parameter int SIZE = fpst_pkg::SIZE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fpst_pkg::KIND_W-1:0]       req_kind,
   input  logic [fpst_pkg::POS_W-1:0]        req_position,
   input  logic signed [fpst_pkg::SUM_W-1:0] req_amount,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [fpst_pkg::SUM_W-1:0] rsp_prefix_sum,
   output logic signed [fpst_pkg::IDX_W-1:0] rsp_found_index
);

   localparam int AW = $clog2(SIZE);

   // node store port
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [fpst_pkg::SUM_W-1:0] mem_wdata;
   logic                       mem_re;
   logic [AW-1:0]              mem_raddr;
   logic [fpst_pkg::SUM_W-1:0] mem_rdata;

   // shared adder: node update on add, accumulate on query,
   // compare and target reduction on search
   fpst_pkg::alu_req_type alu_req;
   fpst_pkg::alu_rsp_type alu_rsp;

   // Sequencer walks the tree one node per read/execute pair:
   //   add    - i, i|(i+1), ... while below SIZE (read, add delta, write back)
   //   query  - p-1, then p &= p-1 until zero (accumulate)
   //   search - power-of-two descent from the largest step not above SIZE
   fpst_seq #(
      .SIZE (SIZE)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .req_amount      (req_amount),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prefix_sum  (rsp_prefix_sum),
      .rsp_found_index (rsp_found_index),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_re          (mem_re),
      .mem_raddr       (mem_raddr),
      .mem_rdata       (mem_rdata),
      .alu_req         (alu_req),
      .alu_rsp         (alu_rsp)
   );

   fpst_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // SIZE x 48-bit node store, no reset: cleared by the sequencer's sweep
   fpst_mem #(
      .DEPTH (SIZE)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

### src/fpst_check.sv
// Port-level checker for the prefix-sum table, bound to the top level.
`include "assert_macros.svh"

module fpst_check (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [fpst_pkg::SUM_W-1:0] rsp_prefix_sum,
   input logic signed [fpst_pkg::IDX_W-1:0] rsp_found_index
);

   logic                                       rsp_held;
   logic                                       rsp_has_sum;
   logic [fpst_pkg::SUM_W+fpst_pkg::IDX_W-1:0] rsp_payload;

   assign rsp_held    = rsp_valid && !rsp_ready;
   assign rsp_has_sum = rsp_valid && (rsp_prefix_sum != '0);
   assign rsp_payload = {rsp_prefix_sum, rsp_found_index};

   // stalled result holds
   `FPST_ASSERT(a_rsp_hold, clock, reset, rsp_held |=> rsp_valid && $stable(rsp_payload))

   // reset starts the clearing pass, no transaction taken
   `FPST_ASSERT_ALWAYS(a_reset_busy, clock, reset |=> !req_ready)

   // one transaction at a time
   `FPST_ASSERT(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready)

   // a result with a nonzero prefix sum never carries a search index
   `FPST_ASSERT(a_fields_apart, clock, reset, rsp_has_sum |-> rsp_found_index == '0)

endmodule

bind fenwick_prefix_sum_table fpst_check u_check (.*);

### dv/tb.sv
// Self-checking testbench for the binary indexed prefix-sum table.
`timescale 1ns / 1ps

module tb;

   localparam int          SIZE         = fpst_pkg::SIZE_DEFAULT;
   localparam int          KIND_W       = fpst_pkg::KIND_W;
   localparam int          POS_W        = fpst_pkg::POS_W;
   localparam int          SUM_W        = fpst_pkg::SUM_W;
   localparam int          IDX_W        = fpst_pkg::IDX_W;
   localparam int unsigned SEARCH_TOP   = 32'd1 << 25;  // first descent step
   localparam int          RANDOM_OPS   = 1700;
   localparam int          QUIET_TAIL   = 150;          // last transactions run without idling
   localparam int          REPORT_LIMIT = 10;
   localparam int          DRAIN_CYCLES = 40;           // longer than the worst latency of one transaction
   localparam int          PRESSURE_AT  = 400;          // accepted count that starts the hold-off
   localparam int          HOLD_CYCLES  = 300;
   localparam int          LIMIT_NS     = 4_000_000;

   localparam logic [KIND_W-1:0] KIND_ADD    = fpst_pkg::KIND_ADD;
   localparam logic [KIND_W-1:0] KIND_QUERY  = fpst_pkg::KIND_QUERY;
   localparam logic [KIND_W-1:0] KIND_SEARCH = fpst_pkg::KIND_SEARCH;
   // Encoding the block ignores: no change, both result fields zero.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam logic [POS_W-1:0] POS_END  = POS_W'(SIZE);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(SIZE - 1);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  position;
      logic [SUM_W-1:0]  amount;
   } op_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [IDX_W-1:0] index;
   } answer_type;

   // ---------------------------------------------------------------------------
   // Clock, reset, block
   // ---------------------------------------------------------------------------
   logic                    clock           = 1'b0;
   logic                    reset           = 1'b1;
   logic                    req_valid       = 1'b0;
   logic                    req_ready;
   logic [KIND_W-1:0]       req_kind        = '0;
   logic [POS_W-1:0]        req_position    = '0;
   logic signed [SUM_W-1:0] req_amount      = '0;
   logic                    rsp_valid;
   logic                    rsp_ready       = 1'b0;
   logic signed [SUM_W-1:0] rsp_prefix_sum;
   logic signed [IDX_W-1:0] rsp_found_index;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   fenwick_prefix_sum_table #(.SIZE(SIZE)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .req_amount      (req_amount),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prefix_sum  (rsp_prefix_sum),
      .rsp_found_index (rsp_found_index)
   );

   // ---------------------------------------------------------------------------
   // Shadow copy of the node store and the prediction of each transaction.
   // Indexing is zero-based: node i covers the range ending at i.
   // ---------------------------------------------------------------------------
   logic [SUM_W-1:0] tree_shadow [SIZE] = '{default: '0};

   // Walk upwards through every node that covers the entry; out of range is a no-op.
   function automatic void shadow_add(logic [POS_W-1:0] at, logic [SUM_W-1:0] delta);
      int unsigned n;
      n = at;
      while (n < SIZE) begin
         tree_shadow[n] = tree_shadow[n] + delta;
         n = n | (n + 1);
      end
   endfunction

   // Exclusive prefix; an end beyond the table saturates to the total.
   function automatic logic [SUM_W-1:0] shadow_prefix(logic [POS_W-1:0] end_pos);
      int unsigned      n;
      logic [SUM_W-1:0] acc;
      n   = (end_pos > SIZE) ? SIZE : end_pos;
      acc = '0;
      while (n > 0) begin
         acc = acc + tree_shadow[n - 1];
         n   = n & (n - 1);
      end
      return acc;
   endfunction

   // Fixed binary descent from the top step; comparisons are 48-bit signed.
   function automatic logic [IDX_W-1:0] shadow_search(logic [SUM_W-1:0] target);
      int unsigned      idx;
      int unsigned      step;
      logic [SUM_W-1:0] rest;
      idx  = 0;
      rest = target;
      if ($signed(target) <= 0)
         return '1;
      for (step = SEARCH_TOP; step != 0; step = step >> 1) begin
         if (idx + step <= SIZE && $signed(tree_shadow[idx + step - 1]) < $signed(rest)) begin
            idx  = idx + step;
            rest = rest - tree_shadow[idx - 1];
         end
      end
      return idx[IDX_W-1:0];
   endfunction

   function automatic answer_type table_step(op_type op);
      answer_type ans;
      ans = '0;
      case (op.kind)
         KIND_ADD:    shadow_add(op.position, op.amount);
         KIND_QUERY:  ans.sum   = shadow_prefix(op.position);
         KIND_SEARCH: ans.index = shadow_search(op.amount);
         default: ;
      endcase
      return ans;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   op_type     ops_pending [$];   // transactions waiting for the driver
   answer_type answers_due [$];   // predicted results, oldest first

   function automatic logic [SUM_W-1:0] rand_amount();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[SUM_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] rand_pos(int unsigned lo, int unsigned hi);
      int unsigned r;
      r = $urandom_range(lo, hi);
      return r[POS_W-1:0];
   endfunction

   // Idling density for the next stretch; zero gives stretches with no gaps.
   function automatic int pct_choice();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 10;
         2:       return 30;
         default: return 60;
      endcase
   endfunction

   task automatic queue_op(logic [KIND_W-1:0] kind, logic [POS_W-1:0] at,
                           logic [SUM_W-1:0] amount);
      op_type op;
      op.kind     = kind;
      op.position = at;
      op.amount   = amount;
      ops_pending = {ops_pending, op};
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus: directed corner cases, then random traffic.
   // Filled at time zero, before the first edge.
   // ---------------------------------------------------------------------------
   initial begin
      longint           gen_total;   // running sum of the well-behaved adds
      int               i;
      int               pick;
      logic [POS_W-1:0] at;
      logic [SUM_W-1:0] delta;

      // empty table
      queue_op(KIND_QUERY,  0,       '0);
      queue_op(KIND_QUERY,  POS_END, '0);
      queue_op(KIND_SEARCH, 0,       '0);                     // target zero
      queue_op(KIND_SEARCH, 0,       {1'b1, {SUM_W-1{1'b0}}}); // most negative target
      queue_op(KIND_SEARCH, 0,       1);                      // unreached on an empty table
      // both ends of the table
      queue_op(KIND_ADD,    0,        5);
      queue_op(KIND_ADD,    POS_LAST, 7);
      // wrap at the field width: max, +1, then min brings entry 512 back to zero
      queue_op(KIND_ADD,    512, {1'b0, {SUM_W-1{1'b1}}});
      queue_op(KIND_QUERY,  513, '0);
      queue_op(KIND_ADD,    512, 1);
      queue_op(KIND_QUERY,  POS_END, '0);
      queue_op(KIND_ADD,    512, {1'b1, {SUM_W-1{1'b0}}});
      // adds outside the table are dropped
      queue_op(KIND_ADD,    POS_END, 100);
      queue_op(KIND_ADD,    '1,      '1);
      // query past the end saturates
      queue_op(KIND_QUERY,  '1,       '0);
      queue_op(KIND_QUERY,  POS_LAST, '0);
      // searches at, between and beyond the prefixes
      queue_op(KIND_SEARCH, 0, 5);
      queue_op(KIND_SEARCH, 0, 6);
      queue_op(KIND_SEARCH, 0, 13);
      // ignored encoding, all bits set
      queue_op(KIND_UNUSED, '1, '1);
      // negative entry: descent still runs, then restore
      queue_op(KIND_ADD,    3, -3);
      queue_op(KIND_SEARCH, 0, 1);
      queue_op(KIND_SEARCH, 0, 2);
      queue_op(KIND_ADD,    3, 3);
      gen_total = 12;

      // Mostly well-formed traffic with small nonnegative deltas so that searches
      // land everywhere; a little noise of wide deltas, wild positions and the
      // unused encoding. Wide deltas are undone two transactions later.
      i = 0;
      while (i < RANDOM_OPS) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            at    = ($urandom_range(0, 99) < 4) ? rand_pos(SIZE, 2047)
                                                : rand_pos(0, SIZE - 1);
            delta = SUM_W'($urandom_range(0, 4095));
            queue_op(KIND_ADD, at, delta);
            if (at < SIZE)
               gen_total += delta;
            i++;
         end else if (pick < 75) begin
            at = ($urandom_range(0, 99) < 5) ? rand_pos(SIZE + 1, 2047)
                                             : rand_pos(0, SIZE);
            queue_op(KIND_QUERY, at, rand_amount());
            i++;
         end else if (pick < 96) begin
            pick = $urandom_range(0, 99);
            if (pick < 90)
               delta = SUM_W'($urandom_range(1, 32'(gen_total + 16)));
            else if (pick < 95)
               delta = -$signed({1'b0, 47'($urandom_range(0, 1000))});
            else
               delta = rand_amount();
            queue_op(KIND_SEARCH, rand_pos(0, 2047), delta);
            i++;
         end else if (pick < 98) begin
            queue_op(KIND_UNUSED, rand_pos(0, 2047), rand_amount());
            i++;
         end else begin
            at    = rand_pos(0, SIZE - 1);
            delta = rand_amount();
            queue_op(KIND_ADD, at, delta);
            if ($urandom_range(0, 1))
               queue_op(KIND_QUERY, rand_pos(0, SIZE), '0);
            else
               queue_op(KIND_SEARCH, 0, rand_amount());
            queue_op(KIND_ADD, at, -delta);
            i += 3;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Driver: offers the next transaction when the bus slot is free, apart from random idle gaps.
   // Valid is held, payload unchanged, until the handshake completes.
   // ---------------------------------------------------------------------------
   op_type op_on_bus;
   int     ops_accepted = 0;
   int     gap_left     = 0;
   int     idle_pct     = 30;
   logic   tail_quiet   = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            answers_due = {answers_due, table_step(op_on_bus)};
            ops_accepted++;
            if (ops_accepted % 200 == 0)
               idle_pct = pct_choice();
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (!tail_quiet && $urandom_range(0, 99) < idle_pct) begin
               // start an idle burst of random length, this one included
               gap_left = $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else if (ops_pending.size() != 0) begin
               op_on_bus = ops_pending.pop_front();
               req_kind     <= op_on_bus.kind;
               req_position <= op_on_bus.position;
               req_amount   <= op_on_bus.amount;
               req_valid    <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         tail_quiet <= (ops_pending.size() < QUIET_TAIL);
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver back-pressure: random stall bursts, plus one long hold-off so
   // that the output register fills and req_ready drops while traffic waits.
   // ---------------------------------------------------------------------------
   logic hold_rsp   = 1'b0;
   int   stall_left = 0;
   int   stall_pct  = 30;
   int   rx_cycles  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         rx_cycles++;
         if (rx_cycles % 500 == 0)
            stall_pct = pct_choice();
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!tail_quiet && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (ops_accepted < PRESSURE_AT)
         @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Monitor: each result against the oldest prediction.
   // ---------------------------------------------------------------------------
   answer_type due;
   int         rsp_seen    = 0;
   int         fault_count = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (answers_due.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("result %0d unexpected: prefix_sum %0d found_index %0d",
                        rsp_seen, rsp_prefix_sum, rsp_found_index);
         end else begin
            due = answers_due.pop_front();
            if (rsp_prefix_sum !== due.sum || rsp_found_index !== due.index) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("result %0d: prefix_sum exp %0d got %0d, found_index exp %0d got %0d",
                           rsp_seen, $signed(due.sum), rsp_prefix_sum,
                           $signed(due.index), rsp_found_index);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // End of run: all stimulus taken, all results back, then a short drain
   // so that a stray extra result is still caught.
   // ---------------------------------------------------------------------------
   initial begin
      @(negedge reset);
      while (ops_pending.size() != 0 || req_valid)
         @(posedge clock);
      while (answers_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("** fenwick_prefix_sum_table: PASSED **");
      else
         $display("** fenwick_prefix_sum_table: FAILED **");
      $finish;
   end

   // Watchdog, well above the slowest legal run (clearing pass included).
   initial begin
      #(LIMIT_NS);
      $display("** fenwick_prefix_sum_table: FAILED **");
      $finish;
   end

endmodule

### fenwick_prefix_sum_table.f
+incdir+src
src/fpst_pkg.sv
src/fpst_mem.sv
src/fpst_alu.sv
src/fpst_seq.sv
src/fenwick_prefix_sum_table.sv
src/fpst_check.sv
dv/tb.sv
